### rtl/matrix_vector_multiply_assert.svh
// assertion macros for the matrix-vector multiply block
// expects clk and rst in the scope of each use
`ifndef MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// consequent in the cycle after the antecedent
`define MVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// consequent in the same cycle as the antecedent
`define MVM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/mvm_pkg.sv
// types and constants for the matrix-vector multiply block
// no dependencies
`timescale 1ns / 1ps

package mvm_pkg;

  localparam int VALUE_W    = 32;
  localparam int SUM_W      = 64;
  localparam int ROW_IDX_W  = 10;
  localparam int ROWS_W     = 11;
  localparam int COLS_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  localparam logic OP_LOAD_X   = 1'b0;
  localparam logic OP_MATRIX   = 1'b1;

  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] row_sum;
    logic [ROW_IDX_W-1:0]    row_index;
    logic                    last_row;
  } out_item_t;

endpackage

### rtl/mvm_vector_store.sv
// storage for the x vector: one write port, one registered read port
// depends on mvm_pkg for the element width
`timescale 1ns / 1ps

module mvm_vector_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic [mvm_pkg::VALUE_W-1:0]       wr_data,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr,
  output logic [mvm_pkg::VALUE_W-1:0]       rd_data
);

  logic [mvm_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/matrix_vector_multiply.sv
// matrix-vector multiply b = A x, top level
// depends on mvm_pkg, mvm_vector_store and matrix_vector_multiply_assert.svh
//
// usage:
//   in channel (in_valid / in_stall / in_item): op 0 loads the next x element,
//   op 1 supplies the next matrix element in row-major order, Q16.16 values.
//   out channel (out_valid / out_stall / out_item): one Q32.32 saturated row
//   sum per row with its row index and a last-row flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 sets
//   the row count, index 1 the column count; cfg_ready is always high.
// throughput: one request per cycle unless in_stall, loads and matrix elements
//   alike; the accumulator does one saturating 64-bit add per cycle when not held
// datapath: a row end passes the stage 1 register (x read at accept), the
//   product register, then is accumulated into the output register; a stall
//   can hold it in either stage.
// reset: counters and accumulator clear, row and column counts become 1, the
//   x store is not cleared and must be loaded before use.
// stall: a waiting row sum holds in the output register; elements that do
//   not end a row keep flowing, and in_stall rises only when a row end
//   reaches the accumulator while the output register is still occupied.
`timescale 1ns / 1ps

module matrix_vector_multiply #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mvm_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mvm_pkg::out_item_t                out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNTW  = $clog2(MAX_COLS + 1);
  localparam int RNW   = $clog2(MAX_ROWS + 1);

  localparam logic signed [mvm_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(mvm_pkg::SUM_W-1){1'b1}}};
  localparam logic signed [mvm_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(mvm_pkg::SUM_W-1){1'b0}}};

  logic [mvm_pkg::ROWS_W-1:0] rows_in_use;
  logic [mvm_pkg::COLS_W-1:0] cols_in_use;
  logic [CNTW-1:0]            ncols;
  logic [RNW-1:0]             nrows;

  logic [AW-1:0] load_count;
  logic [AW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [AW-1:0] load_eff;
  logic [AW-1:0] col_eff;
  logic [RW-1:0] row_eff;
  logic          row_end;
  logic          row_last;

  logic in_accept;
  logic load_accept;
  logic mat_accept;

  logic [mvm_pkg::VALUE_W-1:0] x_rd;

  logic                                s1_v;
  logic signed [mvm_pkg::VALUE_W-1:0]  s1_value;
  logic                                s1_end;
  logic [mvm_pkg::ROW_IDX_W-1:0]       s1_row;
  logic                                s1_last;
  logic                                s1_move;

  logic                                s2_v;
  logic signed [mvm_pkg::SUM_W-1:0]    s2_prod;
  logic                                s2_end;
  logic [mvm_pkg::ROW_IDX_W-1:0]       s2_row;
  logic                                s2_last;
  logic                                s2_fire;

  logic                                out_free;
  logic signed [mvm_pkg::SUM_W-1:0]    acc;
  logic signed [mvm_pkg::SUM_W-1:0]    sum_raw;
  logic signed [mvm_pkg::SUM_W-1:0]    sum_sat;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= mvm_pkg::ROWS_W'(1);
      cols_in_use <= mvm_pkg::COLS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == mvm_pkg::CFG_ROWS) begin
        rows_in_use <= cfg_data[mvm_pkg::ROWS_W-1:0];
      end
      if (cfg_index == mvm_pkg::CFG_COLS) begin
        cols_in_use <= cfg_data[mvm_pkg::COLS_W-1:0];
      end
    end
  end

  always_comb begin
    if (cols_in_use == '0) begin
      ncols = CNTW'(1);
    end else if (32'(cols_in_use) > 32'(MAX_COLS)) begin
      ncols = CNTW'(MAX_COLS);
    end else begin
      ncols = CNTW'(cols_in_use);
    end
    if (rows_in_use == '0) begin
      nrows = RNW'(1);
    end else if (32'(rows_in_use) > 32'(MAX_ROWS)) begin
      nrows = RNW'(MAX_ROWS);
    end else begin
      nrows = RNW'(rows_in_use);
    end
  end

  // handshake and pipeline advance
  assign out_free  = !out_valid || !out_stall;
  assign s2_fire   = s2_v && (!s2_end || out_free);
  assign s1_move   = s1_v && (!s2_v || s2_fire);
  assign in_stall  = s1_v && !s1_move;
  assign in_accept = in_valid && !in_stall;
  assign load_accept = in_accept && (in_item.op == mvm_pkg::OP_LOAD_X);
  assign mat_accept  = in_accept && (in_item.op == mvm_pkg::OP_MATRIX);

  // counters, out-of-bound values fold to zero
  always_comb begin
    load_eff = (32'(load_count) >= 32'(ncols)) ? '0 : load_count;
    col_eff  = (32'(column_count) >= 32'(ncols)) ? '0 : column_count;
    row_eff  = (32'(row_count) >= 32'(nrows)) ? '0 : row_count;
    row_end  = (32'(col_eff) + 32'd1) >= 32'(ncols);
    row_last = (32'(row_eff) + 32'd1) >= 32'(nrows);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count   <= '0;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (load_accept) begin
        load_count <= ((32'(load_eff) + 32'd1) >= 32'(ncols)) ? '0 :
                      AW'(32'(load_eff) + 32'd1);
      end
      if (mat_accept) begin
        column_count <= row_end ? '0 : AW'(32'(col_eff) + 32'd1);
        if (row_end) begin
          row_count <= row_last ? '0 : RW'(32'(row_eff) + 32'd1);
        end
      end
    end
  end

  // x store, read at accept so the data lines up with stage 1
  mvm_vector_store #(
    .DEPTH (MAX_COLS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_accept),
    .wr_addr (load_eff),
    .wr_data (in_item.value),
    .rd_en   (mat_accept),
    .rd_addr (col_eff),
    .rd_data (x_rd)
  );

  // stage 1: element and x entry
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= mat_accept || (s1_v && !s1_move);
    end
  end

  always_ff @(posedge clk) begin
    if (mat_accept) begin
      s1_value <= in_item.value;
      s1_end   <= row_end;
      s1_row   <= mvm_pkg::ROW_IDX_W'(32'(row_eff));
      s1_last  <= row_last;
    end
  end

  // stage 2: product
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_move || (s2_v && !s2_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_prod <= mvm_pkg::SUM_W'(s1_value) * mvm_pkg::SUM_W'($signed(x_rd));
      s2_end  <= s1_end;
      s2_row  <= s1_row;
      s2_last <= s1_last;
    end
  end

  // saturating accumulate
  always_comb begin
    sum_raw = acc + s2_prod;
    if ((acc[mvm_pkg::SUM_W-1] == s2_prod[mvm_pkg::SUM_W-1]) &&
        (sum_raw[mvm_pkg::SUM_W-1] != acc[mvm_pkg::SUM_W-1])) begin
      sum_sat = acc[mvm_pkg::SUM_W-1] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (s2_fire) begin
      acc <= s2_end ? '0 : sum_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire && s2_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_end) begin
      out_item.row_sum   <= sum_sat;
      out_item.row_index <= s2_row;
      out_item.last_row  <= s2_last;
    end
  end

`include "matrix_vector_multiply_assert.svh"

  `MVM_ASSERT_NEXT(a_row_clear, s2_fire && s2_end, acc == '0, "accumulator not cleared after row end")
  `MVM_ASSERT_NEXT(a_end_hold, s2_v && s2_end && out_valid && out_stall, s2_v && s2_end, "row end lost while output stalled")
  `MVM_ASSERT_SAME(a_out_source, $rose(out_valid), $past(s2_fire && s2_end), "output valid without a row end")

endmodule
